/* rtl/core/lispt_pkg.sv */
// ============================================================================
// lispt_pkg
// Shared types and constants for the streaming LIS length tracker.
// ============================================================================
package lispt_pkg;

    // default capacity of the tails store and stored value width
    localparam int MAX_LEN_DEF     = 1024;
    localparam int VALUE_WIDTH_DEF = 32;

    // fixed field widths of the stream ports
    localparam int VALUE_W  = 32;
    localparam int LENGTH_W = 11;
    localparam int S_DATA_W = 32;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 16;

    // one result beat before packing
    typedef struct packed {
        logic                overflow;
        logic [LENGTH_W-1:0] length;
    } res_t;

endpackage

/* rtl/core/lispt_ram.sv */
// ============================================================================
// lispt_ram
// Generic simple dual-port RAM, one write port, one read port, registered read.
// ============================================================================
module lispt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/lispt_ctrl.sv */
// ============================================================================
// lispt_ctrl
// Sequencer: checks the last tail, runs the binary search over the tails RAM
// and writes back the appended or replaced tail.
// ============================================================================
module lispt_ctrl #(
    parameter int MAX_LEN     = lispt_pkg::MAX_LEN_DEF,
    parameter int VALUE_WIDTH = lispt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // item side
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [VALUE_WIDTH-1:0]     in_key,
    input  logic                       in_start,
    // result side
    output logic                       res_valid,
    input  logic                       res_ready,
    output lispt_pkg::res_t            res,
    // tails RAM
    output logic                       ram_we,
    output logic [$clog2(MAX_LEN)-1:0] ram_waddr,
    output logic [VALUE_WIDTH-1:0]     ram_wdata,
    output logic [$clog2(MAX_LEN)-1:0] ram_raddr,
    input  logic [VALUE_WIDTH-1:0]     ram_rdata
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LAST   = 4'b0010,
        ST_SEARCH = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   ovf_reg, ovf_next;
    logic [VALUE_WIDTH-1:0] key_reg, key_next;
    logic [AW-1:0]          lo_reg, lo_next;
    logic [AW-1:0]          hi_reg, hi_next;
    logic [AW-1:0]          mid_reg, mid_next;

    logic [CW-1:0]          count_eff;
    logic [CW-1:0]          count_dec;
    logic [AW-1:0]          last_idx;
    logic                   tail_ge_key;
    logic [AW-1:0]          step_lo;
    logic [AW-1:0]          step_hi;
    logic [AW-1:0]          step_mid;

    // a start beat empties the store before its value is handled
    assign count_eff = in_start ? '0 : count_reg;
    assign count_dec = count_reg - CW'(1);
    assign last_idx  = count_dec[AW-1:0];

    // one binary search step on the tail just read
    assign tail_ge_key = $signed(ram_rdata) >= $signed(key_reg);
    assign step_lo     = tail_ge_key ? lo_reg : mid_reg + AW'(1);
    assign step_hi     = tail_ge_key ? mid_reg : hi_reg;
    assign step_mid    = step_lo + ((step_hi - step_lo) >> 1);

    // next state and RAM access
    always_comb begin
        logic [CW-1:0] eff_dec;
        eff_dec    = count_eff - CW'(1);
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        key_next   = key_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = key_reg;
        ram_raddr  = mid_reg;
        in_ready   = 1'b0;
        res_valid  = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                in_ready  = 1'b1;
                ram_raddr = eff_dec[AW-1:0];
                if (in_valid) begin
                    key_next   = in_key;
                    count_next = count_eff;
                    if (count_eff == '0) begin
                        // empty store: always append at the bottom
                        ram_we     = 1'b1;
                        ram_waddr  = '0;
                        ram_wdata  = in_key;
                        count_next = CW'(1);
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_LAST;
                    end
                end
            end
            ST_LAST: begin
                if ($signed(ram_rdata) < $signed(key_reg)) begin
                    // greater than every tail: append or flag overflow
                    if (count_reg == CW'(MAX_LEN)) begin
                        ovf_next = 1'b1;
                    end else begin
                        ram_we     = 1'b1;
                        ram_waddr  = count_reg[AW-1:0];
                        count_next = count_reg + CW'(1);
                    end
                    state_next = ST_DONE;
                end else if (last_idx == '0) begin
                    // only one tail and it is not below the value
                    ram_we     = 1'b1;
                    ram_waddr  = '0;
                    state_next = ST_DONE;
                end else begin
                    lo_next    = '0;
                    hi_next    = last_idx;
                    mid_next   = last_idx >> 1;
                    ram_raddr  = last_idx >> 1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                lo_next = step_lo;
                hi_next = step_hi;
                if (step_lo == step_hi) begin
                    // lowest tail not below the value; equal rewrites itself
                    ram_we     = 1'b1;
                    ram_waddr  = step_lo;
                    state_next = ST_DONE;
                end else begin
                    mid_next  = step_mid;
                    ram_raddr = step_mid;
                end
            end
            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.length   = lispt_pkg::LENGTH_W'(count_reg);
    assign res.overflow = ovf_reg;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    // search datapath
    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
    end

endmodule

/* rtl/core/lis_patience_tails.sv */
// ============================================================================
// lis_patience_tails
// Streaming longest strictly increasing subsequence length (patience tails).
// ============================================================================
// Usage:
//   s_ channel: one beat per sequence element. s_tdata carries the signed
//   value, s_tuser[0] the start flag, which empties the tails store before
//   that element is handled. The overflow flag is not cleared by a start.
//   m_ channel: one beat per element with the subsequence length so far and
//   the sticky overflow flag (an append dropped because the store was full).
//   Timing: an element into an empty store is written with no search and no
//   read of the tails RAM; one that appends to a non-empty store, or is dropped
//   because the store is full, needs only the read of the last tail; otherwise
//   a binary search follows, one read of the tails RAM per step. s_tready rises
//   again the cycle after the result moves to the output register.
//   Stall: the output register holds a result while m_tready is low; the next
//   element is still accepted and worked on, and waits with its result until
//   the register frees up.
//   Reset: aresetn (synchronous, active low) empties the store and clears the
//   overflow flag; the tails RAM itself is not cleared and needs no sweep.
// ============================================================================
module lis_patience_tails #(
    parameter int MAX_LEN     = lispt_pkg::MAX_LEN_DEF,
    parameter int VALUE_WIDTH = lispt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // element beats
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lispt_pkg::S_DATA_W-1:0] s_tdata,   // [31:0] value
    input  logic [lispt_pkg::S_USER_W-1:0] s_tuser,   // [0] start_req
    // result beats
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lispt_pkg::M_DATA_W-1:0] m_tdata    // [10:0] length, [11] overflow
);

    localparam int AW = $clog2(MAX_LEN);

    logic [VALUE_WIDTH-1:0] in_key;
    logic                   res_valid;
    logic                   res_ready;
    lispt_pkg::res_t        res;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [VALUE_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_rdata;
    logic                   m_valid_reg;
    lispt_pkg::res_t        m_res_reg;

    // value to stored width: truncate or sign-extend
    generate
        if (VALUE_WIDTH <= lispt_pkg::VALUE_W) begin : g_key_trunc
            assign in_key = s_tdata[VALUE_WIDTH-1:0];
        end else begin : g_key_ext
            assign in_key = {{(VALUE_WIDTH - lispt_pkg::VALUE_W){s_tdata[lispt_pkg::VALUE_W-1]}},
                             s_tdata[lispt_pkg::VALUE_W-1:0]};
        end
    endgenerate

    // search and update sequencer
    lispt_ctrl #(
        .MAX_LEN     (MAX_LEN),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_key    (in_key),
        .in_start  (s_tuser[0]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // sorted tails store
    lispt_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (MAX_LEN)
    ) u_tails (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // output register decouples the result beat from the sequencer
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(lispt_pkg::M_DATA_W - lispt_pkg::LENGTH_W - 1){1'b0}},
                       m_res_reg.overflow, m_res_reg.length};

endmodule

/* bench/lis_patience_tails_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// lis_patience_tails_test
// Self-checking bench for the streaming LIS length tracker. A short table of
// directed elements (extremes, ties, replacements, starts) runs first. Random
// sequences of several shapes follow, then one rising run that fills the tails
// store and keeps pushing so the sticky overflow flag is set. Every result beat
// is checked against a local tails tracker or a row's typed result; both stream
// sides idle at random and the result side holds off once for a long stretch.
// ============================================================================
module lis_patience_tails_test;

    localparam int MAX_TAILS      = lispt_pkg::MAX_LEN_DEF;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_ITEMS   = 600;

    // shapes of random element sequences
    typedef enum int {
        CT_WIDE,
        CT_NARROW,
        CT_RISING,
        CT_FALLING,
        CT_EDGES,
        CT_TIES
    } content_t;

    // directed row: start flag, value, typed expectation if obvious
    typedef struct packed {
        logic                           st;
        logic [lispt_pkg::VALUE_W-1:0]  val;
        logic                           has;
        logic [lispt_pkg::LENGTH_W-1:0] len;
        logic                           ovf;
    } dir_row_t;

    typedef struct packed {
        logic            has;
        lispt_pkg::res_t r;
    } typed_exp_t;

    logic                           aclk;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [lispt_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic [lispt_pkg::S_USER_W-1:0] s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [lispt_pkg::M_DATA_W-1:0] m_tdata;

    // tails tracker state
    logic signed [lispt_pkg::VALUE_W-1:0] tail_val [MAX_TAILS];
    int                                   tail_n     = 0;
    logic                                 ovf_sticky = 1'b0;

    lispt_pkg::res_t expected_lengths [$];
    typed_exp_t      typed_q [$];

    int          err_cnt    = 0;
    int          n_in       = 0;
    int          n_out      = 0;
    int          n_starts   = 0;
    int          max_len    = 0;
    int          held_in    = 0;
    int          idle_cyc   = 0;
    int          burst_left = 0;
    int          hold_cnt   = 0;
    bit          hold_req   = 1'b0;
    logic [31:0] walk_val   = '0;

    dir_row_t dir_tab [25] = '{
        '{1'b0, 32'h8000_0000, 1'b1, 11'd1, 1'b0},  // empty store after reset
        '{1'b0, 32'h8000_0000, 1'b0, 11'd0, 1'b0},
        '{1'b0, 32'h7FFF_FFFF, 1'b1, 11'd2, 1'b0},
        '{1'b0, 32'h7FFF_FFFF, 1'b0, 11'd0, 1'b0},
        '{1'b0, 32'h0000_0000, 1'b0, 11'd0, 1'b0},
        '{1'b0, 32'h0000_0005, 1'b0, 11'd0, 1'b0},
        '{1'b0, 32'hFFFF_FFFF, 1'b0, 11'd0, 1'b0},
        '{1'b0, 32'h0000_0003, 1'b0, 11'd0, 1'b0},
        '{1'b0, 32'h0000_0004, 1'b0, 11'd0, 1'b0},
        '{1'b0, 32'h8000_0001, 1'b0, 11'd0, 1'b0},
        '{1'b1, 32'h7FFF_FFFF, 1'b1, 11'd1, 1'b0},  // start empties the store
        '{1'b0, 32'h8000_0000, 1'b0, 11'd0, 1'b0},
        '{1'b1, 32'h0000_0064, 1'b1, 11'd1, 1'b0},
        '{1'b0, 32'h0000_0064, 1'b0, 11'd0, 1'b0},
        '{1'b0, 32'h0000_0032, 1'b0, 11'd0, 1'b0},
        '{1'b0, 32'h0000_0028, 1'b0, 11'd0, 1'b0},
        '{1'b0, 32'h0000_001E, 1'b0, 11'd0, 1'b0},
        '{1'b0, 32'h0000_001F, 1'b0, 11'd0, 1'b0},
        '{1'b0, 32'h0000_0020, 1'b0, 11'd0, 1'b0},
        '{1'b0, 32'h0000_0021, 1'b0, 11'd0, 1'b0},
        '{1'b0, 32'h7FFF_FFFE, 1'b0, 11'd0, 1'b0},
        '{1'b0, 32'h7FFF_FFFF, 1'b0, 11'd0, 1'b0},
        '{1'b1, 32'hFFFF_FFFF, 1'b1, 11'd1, 1'b0},
        '{1'b1, 32'h5555_5555, 1'b1, 11'd1, 1'b0},  // back-to-back starts
        '{1'b0, 32'hAAAA_AAAA, 1'b0, 11'd0, 1'b0}
    };

    lis_patience_tails i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 2 ns clock
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // patience step: append (or flag overflow when full), ignore a tie, or replace the smallest greater tail
    function automatic lispt_pkg::res_t next_lis_length(
        input logic signed [lispt_pkg::VALUE_W-1:0] v, input logic st);
        int              lo;
        int              hi;
        int              mid;
        lispt_pkg::res_t r;
        if (st)
            tail_n = 0;
        if (tail_n == 0 || v > tail_val[tail_n-1]) begin
            if (tail_n < MAX_TAILS) begin
                tail_val[tail_n] = v;
                tail_n++;
            end else begin
                ovf_sticky = 1'b1;
            end
        end else begin
            lo = 0;
            hi = tail_n - 1;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (tail_val[mid] >= v)
                    hi = mid;
                else
                    lo = mid + 1;
            end
            tail_val[lo] = v;
        end
        r.length   = lispt_pkg::LENGTH_W'(tail_n);
        r.overflow = ovf_sticky;
        return r;
    endfunction

    // random element of a given sequence shape
    function automatic logic [31:0] pick_value(input content_t style);
        logic [31:0] v;
        case (style)
            CT_WIDE: begin
                v = $urandom;
            end
            CT_NARROW: begin
                v = $urandom_range(0, 15) - 8;
            end
            CT_RISING: begin
                walk_val = walk_val + $urandom_range(0, 64) - 8;
                v = walk_val;
            end
            CT_FALLING: begin
                walk_val = walk_val - $urandom_range(1, 50);
                v = walk_val;
            end
            CT_EDGES: begin
                case ($urandom_range(0, 5))
                    0: v = 32'h8000_0000;
                    1: v = 32'h8000_0001;
                    2: v = 32'h7FFF_FFFF;
                    3: v = 32'h7FFF_FFFE;
                    4: v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            default: begin
                v = (tail_n > 0) ? tail_val[$urandom_range(0, tail_n - 1)] : $urandom;
            end
        endcase
        return v;
    endfunction

    // value at or just under an existing tail, never an append
    function automatic logic [31:0] below_top();
        logic signed [lispt_pkg::VALUE_W-1:0] t;
        t = tail_val[$urandom_range(0, tail_n - 1)];
        if ($urandom_range(0, 1) == 0 || t == 32'sh8000_0000)
            return t;
        return t - 1;
    endfunction

    // one element beat, with bursts and random gaps in between
    task automatic offer(input logic [31:0] v, input logic st, input logic has,
                         input lispt_pkg::res_t r);
        typed_exp_t te;
        int         gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        te.has = has;
        te.r   = r;
        typed_q = {typed_q, te};
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= st;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // receiver: ready stretches, random stalls, one long hold on request
    initial begin
        int seg_left;
        int seg_mode;
        seg_left = 0;
        seg_mode = 0;
        forever begin
            @(negedge aclk);
            if (hold_cnt == 0 && hold_req) begin
                hold_req = 1'b0;
                hold_cnt = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                m_tready <= 1'b0;
                hold_cnt--;
            end else begin
                if (seg_left == 0) begin
                    seg_mode = $urandom_range(0, 2);
                    seg_left = $urandom_range(5, 60);
                end
                seg_left--;
                case (seg_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= ($urandom_range(0, 1) != 0);
                endcase
            end
        end
    end

    // beat monitor: predict on accepted elements, compare on accepted results
    always @(posedge aclk) begin : mon
        typed_exp_t      te;
        lispt_pkg::res_t pred;
        lispt_pkg::res_t want;
        lispt_pkg::res_t got;
        if (aresetn) begin
            if (s_tvalid && !s_tready && hold_cnt > 0)
                held_in++;
            if (s_tvalid && s_tready) begin
                te   = typed_q.pop_front();
                pred = next_lis_length($signed(s_tdata[lispt_pkg::VALUE_W-1:0]), s_tuser[0]);
                want = te.has ? te.r : pred;
                expected_lengths = {expected_lengths, want};
                n_in++;
                if (s_tuser[0])
                    n_starts++;
                if (tail_n > max_len)
                    max_len = tail_n;
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[lispt_pkg::LENGTH_W:0];
                n_out++;
                if (expected_lengths.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch: result beat %0d with none pending, len=%0d ovf=%0b",
                                 n_out, got.length, got.overflow);
                end else begin
                    want = expected_lengths.pop_front();
                    if (got.length != want.length || got.overflow != want.overflow) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("mismatch: beat %0d len exp %0d got %0d, ovf exp %0b got %0b",
                                     n_out, want.length, got.length, want.overflow,
                                     got.overflow);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cyc = 0;
        else
            idle_cyc++;
        if (idle_cyc == WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results pending",
                     idle_cyc, expected_lengths.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        lispt_pkg::res_t row_r;
        content_t        style;
        int              n;
        int              seq_len;
        logic            st;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed rows
        foreach (dir_tab[i]) begin
            row_r.length   = dir_tab[i].len;
            row_r.overflow = dir_tab[i].ovf;
            offer(dir_tab[i].val, dir_tab[i].st, dir_tab[i].has, row_r);
        end

        // random sequences of mixed shapes, mostly opened by a start
        row_r = '0;
        n = 0;
        while (n < RANDOM_ITEMS) begin
            style    = content_t'($urandom_range(0, 5));
            seq_len  = $urandom_range(1, 40);
            walk_val = $urandom;
            for (int k = 0; k < seq_len; k++) begin
                st = (k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 31) == 0);
                if (n == 200)
                    hold_req = 1'b1;
                offer(pick_value(style), st, 1'b0, row_r);
                n++;
            end
        end

        // rising run across the whole value range until the store is full
        for (int b = 0; b < MAX_TAILS; b++) begin
            if (b > 0 && $urandom_range(0, 7) == 0)
                offer(below_top(), 1'b0, 1'b0, row_r);
            offer(32'h8000_0000 + 32'(b) * 32'h0040_0000 + $urandom_range(0, 32'h003F_FFFF),
                  (b == 0), 1'b0, row_r);
        end

        // full store: dropped appends, deep searches, ties
        for (int k = 0; k < 60; k++) begin
            case ($urandom_range(0, 3))
                0: offer(32'h7FFF_FFFF, 1'b0, 1'b0, row_r);
                1: offer($urandom, 1'b0, 1'b0, row_r);
                2: offer(pick_value(CT_TIES), 1'b0, 1'b0, row_r);
                default: offer(below_top(), 1'b0, 1'b0, row_r);
            endcase
        end

        // starts after overflow leave the flag set
        for (int k = 0; k < 20; k++)
            offer(pick_value(CT_WIDE), (k % 5 == 0), 1'b0, row_r);

        s_tvalid <= 1'b0;
        while (expected_lengths.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("ran %0d elements (%0d starts) and checked %0d result beats",
                 n_in, n_starts, n_out);
        $display("longest length %0d of %0d, overflow set: %0b, input held %0d cycles",
                 max_len, MAX_TAILS, ovf_sticky, held_in);
        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/lispt_pkg.sv
rtl/core/lispt_ram.sv
rtl/core/lispt_ctrl.sv
rtl/core/lis_patience_tails.sv
bench/lis_patience_tails_test.sv
